@@ design/cs8r_pkg.sv @@
// shared types and constants for the checksum-8 packet receiver
// no dependencies; imported by every module of the block
package cs8r_pkg;

    localparam int BUFFER_BYTES = 128;
    localparam int KEEP_BYTES   = 12;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_COUNT    = 6;
    localparam int ADDR_W       = $clog2(CFG_COUNT) + 2;

    localparam logic [7:0] HEADER_BYTE = 8'h7E;

    // input item kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_ARM  = 2'd2;

    // register indexes
    localparam logic [ADDR_W-3:0] REG_WAIT_LIMIT = 3'd0;
    localparam logic [ADDR_W-3:0] REG_CODE_ENC1  = 3'd1;
    localparam logic [ADDR_W-3:0] REG_CODE_ENC2  = 3'd2;
    localparam logic [ADDR_W-3:0] REG_CODE_ENC3  = 3'd3;
    localparam logic [ADDR_W-3:0] REG_CODE_ALL   = 3'd4;
    localparam logic [ADDR_W-3:0] REG_CODE_POSE  = 3'd5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_BAD_HDR  = 3'd2,
        ST_NO_CMD   = 3'd3,
        ST_BAD_LEN  = 3'd4,
        ST_SHORT    = 3'd5,
        ST_CSUM     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_CMD,
        PH_LEN,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ENC1,
        ACT_ENC2,
        ACT_ENC3,
        ACT_ALL,
        ACT_POSE
    } act_t;

    typedef struct packed {
        logic [7:0] wait_limit;
        logic [7:0] code_enc1;
        logic [7:0] code_enc2;
        logic [7:0] code_enc3;
        logic [7:0] code_all;
        logic [7:0] code_pose;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command_seen;
        logic [31:0] enc1_value;
        logic [31:0] enc2_value;
        logic [31:0] enc3_value;
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [31:0] pose_theta;
    } result_t;

    // packet outcome handed from the parser to the update stage
    typedef struct packed {
        status_t                        status;
        logic [7:0]                     command;
        act_t                           action;
        logic [KEEP_BYTES-1:0][7:0]     capture;
    } rec_t;

endpackage

@@ design/cs8r_front.sv @@
// packet parser: frames bytes and ticks, emits one record per finished packet
// depends on cs8r_pkg
module cs8r_front (
    input  logic            clk,
    input  logic            rst_n,
    input  cs8r_pkg::cfg_t  cfg,
    input  logic            accept,
    input  cs8r_pkg::item_t item,
    output logic            fin_valid,
    output cs8r_pkg::rec_t  fin_rec
);
    import cs8r_pkg::*;

    phase_t                     phase_reg, phase_next;
    logic [7:0]                 tick_reg, tick_next;
    logic [7:0]                 cmd_reg, cmd_next;
    logic [7:0]                 len_reg, len_next;
    logic [7:0]                 pos_reg, pos_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [KEEP_BYTES-1:0][7:0] cap_reg, cap_next;

    logic [7:0] tick_inc;
    logic       len_bad;
    logic       more_data;
    logic       is_byte;
    logic       is_tick;
    logic       is_arm;
    logic       fin;
    status_t    fin_status;
    act_t       action;

    assign is_byte   = accept && (item.kind == KIND_BYTE);
    assign is_tick   = accept && (item.kind == KIND_TICK);
    assign is_arm    = accept && (item.kind == KIND_ARM);
    assign tick_inc  = (tick_reg == 8'hFF) ? tick_reg : tick_reg + 8'd1;
    assign len_bad   = (item.rx_byte < 8'd2) || ({1'b0, item.rx_byte} > 9'(BUFFER_BYTES));
    assign more_data = ({1'b0, pos_reg} + 9'd2) < {1'b0, len_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_arm)
        begin
            phase_next = PH_HDR;
        end
        else if (fin)
        begin
            phase_next = PH_IDLE;
        end
        else if (is_byte)
        begin
            unique case (phase_reg)
                PH_HDR:  phase_next = PH_CMD;
                PH_CMD:  phase_next = PH_LEN;
                PH_LEN:  phase_next = PH_DATA;
                default: phase_next = phase_reg;
            endcase
        end
    end

    // finish decision and datapath
    always_comb
    begin
        fin        = 1'b0;
        fin_status = ST_OK;
        tick_next  = tick_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        cap_next   = cap_reg;
        if (is_arm)
        begin
            tick_next = '0;
            cmd_next  = '0;
            len_next  = '0;
            pos_next  = '0;
            sum_next  = '0;
        end
        else if (is_tick)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.wait_limit)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_TIMEOUT;
                    end
                end
                PH_CMD:
                begin
                    fin        = 1'b1;
                    fin_status = ST_NO_CMD;
                end
                PH_LEN:
                begin
                    fin        = 1'b1;
                    fin_status = ST_BAD_LEN;
                end
                PH_DATA:
                begin
                    fin        = 1'b1;
                    fin_status = ST_SHORT;
                end
                default: fin = 1'b0;
            endcase
        end
        else if (is_byte)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (item.rx_byte != HEADER_BYTE)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_BAD_HDR;
                    end
                    else
                    begin
                        cap_next = '0;
                    end
                end
                PH_CMD:
                begin
                    cmd_next = item.rx_byte;
                    sum_next = item.rx_byte;
                end
                PH_LEN:
                begin
                    len_next = item.rx_byte;
                    if (len_bad)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_BAD_LEN;
                    end
                    else
                    begin
                        sum_next = sum_reg + item.rx_byte;
                        pos_next = '0;
                    end
                end
                PH_DATA:
                begin
                    if (more_data)
                    begin
                        if (pos_reg < 8'(KEEP_BYTES))
                        begin
                            cap_next[pos_reg[$clog2(KEEP_BYTES)-1:0]] = item.rx_byte;
                        end
                        sum_next = sum_reg + item.rx_byte;
                        pos_next = pos_reg + 8'd1;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = (item.rx_byte == sum_reg) ? ST_OK : ST_CSUM;
                    end
                end
                default: fin = 1'b0;
            endcase
        end
    end

    // command decode, first match wins
    always_comb
    begin
        priority if (fin_status != ST_OK)
            action = ACT_NONE;
        else if (cmd_reg == cfg.code_enc1)
            action = ACT_ENC1;
        else if (cmd_reg == cfg.code_enc2)
            action = ACT_ENC2;
        else if (cmd_reg == cfg.code_enc3)
            action = ACT_ENC3;
        else if (cmd_reg == cfg.code_all)
            action = ACT_ALL;
        else if (cmd_reg == cfg.code_pose)
            action = ACT_POSE;
        else
            action = ACT_NONE;
    end

    assign fin_valid       = fin;
    assign fin_rec.status  = fin_status;
    assign fin_rec.command = cmd_reg;
    assign fin_rec.action  = action;
    assign fin_rec.capture = cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            cap_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            cap_reg   <= cap_next;
        end
    end

    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> phase_reg == PH_IDLE)
        else $error("parser did not return to idle after a packet ended");

    a_arm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        is_arm |=> (phase_reg == PH_HDR) && (tick_reg == 8'd0) && (cmd_reg == 8'd0))
        else $error("arm did not restart the header wait");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> ({1'b0, pos_reg} + 9'd2) <= {1'b0, len_reg})
        else $error("data position ran past the packet length");

endmodule

@@ design/cs8r_queue.sv @@
// two-entry queue of packet records between parser and update stage
// depends on cs8r_pkg
module cs8r_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cs8r_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output cs8r_pkg::rec_t pop_rec,
    output logic           empty
);
    import cs8r_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    rec_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/cs8r_back.sv @@
// update stage: applies a packet record to the stored words, holds the result beat
// depends on cs8r_pkg
module cs8r_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_avail,
    input  cs8r_pkg::rec_t    rec,
    output logic              rec_take,
    output cs8r_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);
    import cs8r_pkg::*;

    logic [31:0] enc1_reg, enc1_next;
    logic [31:0] enc2_reg, enc2_next;
    logic [31:0] enc3_reg, enc3_next;
    logic [31:0] px_reg, px_next;
    logic [31:0] py_reg, py_next;
    logic [31:0] pt_reg, pt_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    logic        adv;
    logic [31:0] w0, w1, w2;

    // little-endian words from the kept bytes
    assign w0 = rec.capture[3:0];
    assign w1 = rec.capture[7:4];
    assign w2 = rec.capture[11:8];

    assign adv      = rec_avail && (!out_valid_reg || pop);
    assign rec_take = adv;

    always_comb
    begin
        enc1_next = enc1_reg;
        enc2_next = enc2_reg;
        enc3_next = enc3_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        pt_next   = pt_reg;
        if (adv)
        begin
            unique case (rec.action)
                ACT_ENC1: enc1_next = w0;
                ACT_ENC2: enc2_next = w0;
                ACT_ENC3: enc3_next = w0;
                ACT_ALL:
                begin
                    enc1_next = w0;
                    enc2_next = w1;
                    enc3_next = w2;
                end
                ACT_POSE:
                begin
                    px_next = w0;
                    py_next = w1;
                    pt_next = w2;
                end
                default: enc1_next = enc1_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc1_reg      <= '0;
            enc2_reg      <= '0;
            enc3_reg      <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            pt_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            enc1_reg      <= enc1_next;
            enc2_reg      <= enc2_next;
            enc3_reg      <= enc3_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            pt_reg        <= pt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.status       <= rec.status;
            out_reg.command_seen <= rec.command;
            out_reg.enc1_value   <= enc1_next;
            out_reg.enc2_value   <= enc2_next;
            out_reg.enc3_value   <= enc3_next;
            out_reg.pose_x       <= px_next;
            out_reg.pose_y       <= py_next;
            out_reg.pose_theta   <= pt_next;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

@@ design/checksum8_packet_receiver.sv @@
// top level: config registers, parser, record queue and update stage
// depends on cs8r_pkg, cs8r_front, cs8r_queue, cs8r_back
//
//   port group    direction  handshake                 beat
//   item          in         push / full               kind, rx_byte
//   result        out        pop / empty               status, command, six words
//   apb           in/out     psel penable pwrite pready  one 8-bit register
//
// one item is taken every cycle while full is low; full is high while two
// packet records wait in the queue behind an unread result beat, even in a
// cycle whose pop frees the result register.
// a packet's result reaches the ports through the record queue, written at
// the edge that takes its last item, then the update stage's output register,
// written when that stage takes the record. reset clears all stored words and
// needs no clearing pass; result stalls back up through the queue into full.
module checksum8_packet_receiver (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  cs8r_pkg::item_t                        item,
    input  logic                                   pop,
    output logic                                   empty,
    output cs8r_pkg::result_t                      result,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cs8r_pkg::ADDR_W-1:0]            paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import cs8r_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        wr_en;
    logic [ADDR_W-3:0] reg_idx;
    logic        accept;
    logic        fin_valid;
    rec_t        fin_rec;
    rec_t        q_rec;
    logic        q_full;
    logic        q_empty;
    logic        q_take;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_WAIT_LIMIT: cfg_next.wait_limit = pwdata[7:0];
                REG_CODE_ENC1:  cfg_next.code_enc1  = pwdata[7:0];
                REG_CODE_ENC2:  cfg_next.code_enc2  = pwdata[7:0];
                REG_CODE_ENC3:  cfg_next.code_enc3  = pwdata[7:0];
                REG_CODE_ALL:   cfg_next.code_all   = pwdata[7:0];
                REG_CODE_POSE:  cfg_next.code_pose  = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WAIT_LIMIT: prdata = {24'd0, cfg_reg.wait_limit};
            REG_CODE_ENC1:  prdata = {24'd0, cfg_reg.code_enc1};
            REG_CODE_ENC2:  prdata = {24'd0, cfg_reg.code_enc2};
            REG_CODE_ENC3:  prdata = {24'd0, cfg_reg.code_enc3};
            REG_CODE_ALL:   prdata = {24'd0, cfg_reg.code_all};
            REG_CODE_POSE:  prdata = {24'd0, cfg_reg.code_pose};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_limit <= 8'd50;
            cfg_reg.code_enc1  <= 8'd49;
            cfg_reg.code_enc2  <= 8'd50;
            cfg_reg.code_enc3  <= 8'd51;
            cfg_reg.code_all   <= 8'd65;
            cfg_reg.code_pose  <= 8'd80;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    cs8r_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .item      (item),
        .fin_valid (fin_valid),
        .fin_rec   (fin_rec)
    );

    cs8r_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fin_valid),
        .push_rec (fin_rec),
        .full     (q_full),
        .pop      (q_take),
        .pop_rec  (q_rec),
        .empty    (q_empty)
    );

    cs8r_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_avail (!q_empty),
        .rec       (q_rec),
        .rec_take  (q_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
